// ===== hdl/chtd_pkg.sv =====
// ----------------------------------------------------------------------------
// chtd_pkg
// Shared sizes, codes and controller/datapath interface types for the
// canonical Huffman table decoder.
// ----------------------------------------------------------------------------
package chtd_pkg;

   localparam int SYMBOLS = 512;
   localparam int MAX_LEN = 15;

   localparam int SYM_W  = $clog2(SYMBOLS);
   localparam int CNT_W  = 10;
   localparam int LEN_W  = 4;
   localparam int WIN_W  = 15;
   localparam int FILL_W = 7;
   localparam int USED_W = 4;
   localparam int MCL_W  = 4;
   localparam int OP_W   = 2;
   localparam int ST_W   = 3;
   localparam int LIDX_W = $clog2(MAX_LEN + 1);
   localparam int AV_W   = MAX_LEN + 2;
   localparam int SUM_W  = MAX_LEN + 1;
   localparam int CMP_W  = (CNT_W > MAX_LEN + 1) ? CNT_W : MAX_LEN + 1;
   localparam int P_W    = ((MAX_LEN > CNT_W) ? MAX_LEN : CNT_W) + 1;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_BUILD  = 2'd1,
      OP_DECODE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 3'd0,
      ST_TOO_LONG   = 3'd1,
      ST_SIZE       = 3'd2,
      ST_NO_CODES   = 3'd3,
      ST_OVERSUB    = 3'd4,
      ST_INCOMPLETE = 3'd5,
      ST_SHORT      = 3'd6,
      ST_NO_TABLE   = 3'd7
   } status_type;

   typedef enum logic {
      REG_MAX_LEN   = 1'b0,
      REG_SYM_COUNT = 1'b1
   } reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SIZE_CHK,
      S_CNT_RD,
      S_CNT_USE,
      S_ZERO_CHK,
      S_KRAFT,
      S_FIRST,
      S_PLACE,
      S_SORT_RD,
      S_SORT_USE,
      S_DEC_STEP,
      S_DEC_DATA,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic       capture;
      logic       len_write;
      logic       set_status;
      status_type status;
      logic       size_prep;
      logic       cnt_inc;
      logic       kraft_init;
      logic       kraft_step;
      logic       first_init;
      logic       first_step;
      logic       place_init;
      logic       place_step;
      logic       sort_init;
      logic       sort_step;
      logic       commit;
      logic       dec_step;
      logic       dec_read;
      logic       dec_data;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic size_bad;
      logic size_zero;
      logic sym_last;
      logic len_bad;
      logic all_zero;
      logic kraft_neg;
      logic kraft_nz;
      logic kraft_last;
      logic first_last;
      logic place_last;
      logic dec_match;
      logic dec_short;
      logic dec_last;
      logic table_ok;
   } flags_type;

endpackage

// ===== hdl/canonical_huffman_table_decoder_core.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_table_decoder_core
// Canonical Huffman decoder with a table built from per-symbol code lengths.
// ----------------------------------------------------------------------------
// One command is in flight at a time and each gives one result. A length load
// writes the length store when it is taken. In a build the length store has
// one read port, read through a read state and a use state per symbol on each
// of its two sweeps (counting, then sorting), and the code space check, first
// codes and symbol bases each take one step per length. A decode matches the
// code one bit per cycle, followed by one read of the sorted symbol store. A
// finished result waits in an output register, so the next command is taken
// while it is still stalled.
module canonical_huffman_table_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [chtd_pkg::OP_W-1:0]      req_opcode,
   input  logic [chtd_pkg::SYM_W-1:0]     req_symbol_index,
   input  logic [chtd_pkg::LEN_W-1:0]     req_code_length,
   input  logic [chtd_pkg::WIN_W-1:0]     req_bit_window,
   input  logic [chtd_pkg::FILL_W-1:0]    req_bits_available,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [chtd_pkg::ST_W-1:0]      rsp_status,
   output logic [chtd_pkg::SYM_W-1:0]     rsp_symbol,
   output logic [chtd_pkg::USED_W-1:0]    rsp_bits_used,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [chtd_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [chtd_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [chtd_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);

   logic [chtd_pkg::MCL_W-1:0] max_len_ff;
   logic [chtd_pkg::CNT_W-1:0] sym_count_ff;
   logic                       csr_write;
   chtd_pkg::reg_type          csr_reg;
   chtd_pkg::cmd_type          cmd;
   chtd_pkg::flags_type        flags;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = chtd_pkg::reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= chtd_pkg::MCL_W'(chtd_pkg::MAX_LEN);
         sym_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_reg)
            chtd_pkg::REG_MAX_LEN:   max_len_ff   <= csr_pwdata[chtd_pkg::MCL_W-1:0];
            chtd_pkg::REG_SYM_COUNT: sym_count_ff <= csr_pwdata[chtd_pkg::CNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         chtd_pkg::REG_MAX_LEN:   csr_prdata = chtd_pkg::CSR_DW'(max_len_ff);
         chtd_pkg::REG_SYM_COUNT: csr_prdata = chtd_pkg::CSR_DW'(sym_count_ff);
      endcase
   end

   chtd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .flags      (flags),
      .cmd        (cmd)
   );

   chtd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .flags              (flags),
      .req_symbol_index   (req_symbol_index),
      .req_code_length    (req_code_length),
      .req_bit_window     (req_bit_window),
      .req_bits_available (req_bits_available),
      .cfg_max_len        (max_len_ff),
      .cfg_size           (sym_count_ff),
      .rsp_status         (rsp_status),
      .rsp_symbol         (rsp_symbol),
      .rsp_bits_used      (rsp_bits_used)
   );

endmodule

// ===== hdl/chtd_ram.sv =====
// ----------------------------------------------------------------------------
// chtd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/chtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// chtd_ctrl
// Sequencer for load, build and decode, plus the result handshake.
// ----------------------------------------------------------------------------
module chtd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [chtd_pkg::OP_W-1:0]  req_opcode,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  chtd_pkg::flags_type        flags,
   output chtd_pkg::cmd_type          cmd
);

   chtd_pkg::fsm_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chtd_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (chtd_pkg::op_type'(req_opcode))
                  chtd_pkg::OP_BUILD:  state_in = chtd_pkg::S_SIZE_CHK;
                  chtd_pkg::OP_DECODE: state_in = flags.table_ok ? chtd_pkg::S_DEC_STEP
                                                                 : chtd_pkg::S_DONE;
                  chtd_pkg::OP_LOAD,
                  chtd_pkg::OP_NOP:    state_in = chtd_pkg::S_DONE;
               endcase
            end
         end
         chtd_pkg::S_SIZE_CHK: begin
            priority if (flags.size_bad)  state_in = chtd_pkg::S_DONE;
            else if (flags.size_zero)     state_in = chtd_pkg::S_ZERO_CHK;
            else                          state_in = chtd_pkg::S_CNT_RD;
         end
         chtd_pkg::S_CNT_RD: state_in = chtd_pkg::S_CNT_USE;
         chtd_pkg::S_CNT_USE: begin
            priority if (flags.len_bad)   state_in = chtd_pkg::S_DONE;
            else if (flags.sym_last)      state_in = chtd_pkg::S_ZERO_CHK;
            else                          state_in = chtd_pkg::S_CNT_RD;
         end
         chtd_pkg::S_ZERO_CHK: begin
            state_in = flags.all_zero ? chtd_pkg::S_DONE : chtd_pkg::S_KRAFT;
         end
         chtd_pkg::S_KRAFT: begin
            priority if (flags.kraft_neg) state_in = chtd_pkg::S_DONE;
            else if (flags.kraft_last)    state_in = flags.kraft_nz ? chtd_pkg::S_DONE
                                                                    : chtd_pkg::S_FIRST;
            else                          state_in = chtd_pkg::S_KRAFT;
         end
         chtd_pkg::S_FIRST: begin
            if (flags.first_last) state_in = chtd_pkg::S_PLACE;
         end
         chtd_pkg::S_PLACE: begin
            if (flags.place_last) state_in = chtd_pkg::S_SORT_RD;
         end
         chtd_pkg::S_SORT_RD: state_in = chtd_pkg::S_SORT_USE;
         chtd_pkg::S_SORT_USE: begin
            state_in = flags.sym_last ? chtd_pkg::S_DONE : chtd_pkg::S_SORT_RD;
         end
         chtd_pkg::S_DEC_STEP: begin
            priority if (flags.dec_match) state_in = flags.dec_short ? chtd_pkg::S_DONE
                                                                     : chtd_pkg::S_DEC_DATA;
            else if (flags.dec_last)      state_in = chtd_pkg::S_DONE;
            else                          state_in = chtd_pkg::S_DEC_STEP;
         end
         chtd_pkg::S_DEC_DATA: state_in = chtd_pkg::S_DONE;
         chtd_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = chtd_pkg::S_IDLE;
         end
         default: state_in = chtd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = chtd_pkg::ST_OK;
      unique case (state_ff)
         chtd_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (chtd_pkg::op_type'(req_opcode) == chtd_pkg::OP_LOAD) begin
                  cmd.len_write = 1'b1;
               end
               if (chtd_pkg::op_type'(req_opcode) == chtd_pkg::OP_DECODE &&
                   !flags.table_ok) begin
                  cmd.status = chtd_pkg::ST_NO_TABLE;
               end
            end
         end
         chtd_pkg::S_SIZE_CHK: begin
            if (flags.size_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = chtd_pkg::ST_SIZE;
            end else begin
               cmd.size_prep = 1'b1;
            end
         end
         chtd_pkg::S_CNT_USE: begin
            if (flags.len_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = chtd_pkg::ST_TOO_LONG;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         chtd_pkg::S_ZERO_CHK: begin
            if (flags.all_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = chtd_pkg::ST_NO_CODES;
            end else begin
               cmd.kraft_init = 1'b1;
            end
         end
         chtd_pkg::S_KRAFT: begin
            cmd.kraft_step = 1'b1;
            priority if (flags.kraft_neg) begin
               cmd.set_status = 1'b1;
               cmd.status     = chtd_pkg::ST_OVERSUB;
            end else if (flags.kraft_last && flags.kraft_nz) begin
               cmd.set_status = 1'b1;
               cmd.status     = chtd_pkg::ST_INCOMPLETE;
            end else if (flags.kraft_last) begin
               cmd.first_init = 1'b1;
            end else begin
            end
         end
         chtd_pkg::S_FIRST: begin
            cmd.first_step = 1'b1;
            cmd.place_init = flags.first_last;
         end
         chtd_pkg::S_PLACE: begin
            cmd.place_step = 1'b1;
            cmd.sort_init  = flags.place_last;
         end
         chtd_pkg::S_SORT_USE: begin
            cmd.sort_step  = 1'b1;
            cmd.commit     = flags.sym_last;
            cmd.set_status = flags.sym_last;
         end
         chtd_pkg::S_DEC_STEP: begin
            priority if (flags.dec_match && flags.dec_short) begin
               cmd.set_status = 1'b1;
               cmd.status     = chtd_pkg::ST_SHORT;
            end else if (flags.dec_match) begin
               cmd.dec_read = 1'b1;
            end else begin
               cmd.dec_step = 1'b1;
               if (flags.dec_last) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = chtd_pkg::ST_NO_TABLE;
               end
            end
         end
         chtd_pkg::S_DEC_DATA: begin
            cmd.dec_data   = 1'b1;
            cmd.set_status = 1'b1;
         end
         chtd_pkg::S_DONE: begin
            cmd.out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall)       rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chtd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != chtd_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/chtd_dp.sv =====
// ----------------------------------------------------------------------------
// chtd_dp
// Datapath: length store, length counts, code space check, first codes,
// symbol bases, sorted symbol store, bit-serial decode and result register.
// ----------------------------------------------------------------------------
module chtd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  chtd_pkg::cmd_type             cmd,
   output chtd_pkg::flags_type           flags,
   input  logic [chtd_pkg::SYM_W-1:0]    req_symbol_index,
   input  logic [chtd_pkg::LEN_W-1:0]    req_code_length,
   input  logic [chtd_pkg::WIN_W-1:0]    req_bit_window,
   input  logic [chtd_pkg::FILL_W-1:0]   req_bits_available,
   input  logic [chtd_pkg::MCL_W-1:0]    cfg_max_len,
   input  logic [chtd_pkg::CNT_W-1:0]    cfg_size,
   output logic [chtd_pkg::ST_W-1:0]     rsp_status,
   output logic [chtd_pkg::SYM_W-1:0]    rsp_symbol,
   output logic [chtd_pkg::USED_W-1:0]   rsp_bits_used
);

   localparam int SYM_W  = chtd_pkg::SYM_W;
   localparam int CNT_W  = chtd_pkg::CNT_W;
   localparam int LEN_W  = chtd_pkg::LEN_W;
   localparam int LIDX_W = chtd_pkg::LIDX_W;
   localparam int MAX_LEN = chtd_pkg::MAX_LEN;
   localparam int AV_W   = chtd_pkg::AV_W;
   localparam int SUM_W  = chtd_pkg::SUM_W;
   localparam int CMP_W  = chtd_pkg::CMP_W;
   localparam int P_W    = chtd_pkg::P_W;

   // Shared loop index: symbol index during the store sweeps, length otherwise.
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [LIDX_W-1:0]  lidx;

   logic [CNT_W-1:0]   counts_ff [MAX_LEN+1];
   logic [MAX_LEN-1:0] first_ff  [MAX_LEN];
   logic [CNT_W-1:0]   base_ff   [MAX_LEN];
   logic [CNT_W-1:0]   cursor_ff [MAX_LEN];

   logic signed [AV_W-1:0] avail_ff, avail_in;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W:0]     sum_add;
   logic [CNT_W-1:0]   off_ff, off_in;

   logic               valid_ff;
   logic [LIDX_W-1:0]  built_max_ff;
   logic [CNT_W-1:0]   built_size_ff;

   logic [MAX_LEN-1:0] v_ff, v_cur;
   logic [chtd_pkg::WIN_W-1:0]  win_ff;
   logic [chtd_pkg::FILL_W-1:0] fill_ff;
   logic [P_W-1:0]     ptr;

   logic [LIDX_W-1:0]  maxb;
   logic [CMP_W-1:0]   limit;
   logic [LEN_W-1:0]   len_rdata;
   logic [LIDX_W-1:0]  slot;
   logic               sort_we;
   logic [SYM_W-1:0]   sym_rdata;

   chtd_pkg::status_type            res_status_ff;
   logic [SYM_W-1:0]                res_symbol_ff;
   logic [chtd_pkg::USED_W-1:0]     res_used_ff;
   logic [chtd_pkg::ST_W-1:0]       out_status_ff;
   logic [SYM_W-1:0]                out_symbol_ff;
   logic [chtd_pkg::USED_W-1:0]     out_used_ff;

   assign lidx  = idx_ff[LIDX_W-1:0];
   assign maxb  = (cfg_max_len > MAX_LEN) ? LIDX_W'(MAX_LEN) : LIDX_W'(cfg_max_len);
   assign limit = CMP_W'(1) << maxb;

   chtd_ram #(.WIDTH(LEN_W), .DEPTH(chtd_pkg::SYMBOLS)) u_len_ram (
      .clock (clock),
      .we    (cmd.len_write),
      .waddr (req_symbol_index),
      .wdata (req_code_length),
      .raddr (idx_ff[SYM_W-1:0]),
      .rdata (len_rdata)
   );

   // Symbols of each length are placed from that length's running cursor.
   assign slot    = LIDX_W'(len_rdata - 1'b1);
   assign sort_we = cmd.sort_step && (len_rdata != '0);

   assign v_cur = MAX_LEN'({v_ff, win_ff[0]});
   assign ptr   = P_W'(v_cur) - P_W'(first_ff[lidx]) + P_W'(base_ff[lidx]);

   chtd_ram #(.WIDTH(SYM_W), .DEPTH(chtd_pkg::SYMBOLS)) u_sym_ram (
      .clock (clock),
      .we    (sort_we),
      .waddr (cursor_ff[slot][SYM_W-1:0]),
      .wdata (idx_ff[SYM_W-1:0]),
      .raddr (ptr[SYM_W-1:0]),
      .rdata (sym_rdata)
   );

   assign avail_in = (avail_ff <<< 1) - signed'(AV_W'(counts_ff[lidx]));
   assign sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(counts_ff[lidx]);
   assign off_in   = off_ff + counts_ff[LIDX_W'(lidx + 1'b1)];

   always_comb begin
      flags.size_bad   = (CMP_W'(cfg_size) > CMP_W'(chtd_pkg::SYMBOLS)) ||
                         (CMP_W'(cfg_size) > limit);
      flags.size_zero  = (cfg_size == '0);
      flags.sym_last   = (idx_ff == cfg_size - 1'b1);
      flags.len_bad    = (LIDX_W'(len_rdata) > maxb);
      flags.all_zero   = (counts_ff[0] == cfg_size);
      flags.kraft_neg  = avail_in[AV_W-1];
      flags.kraft_nz   = (avail_in != '0);
      flags.kraft_last = (lidx == maxb);
      flags.first_last = (lidx == LIDX_W'(1));
      flags.place_last = (lidx == maxb - 1'b1);
      flags.dec_match  = (v_cur >= first_ff[lidx]);
      flags.dec_short  = (int'(fill_ff) < int'(lidx) + 1);
      flags.dec_last   = (lidx == built_max_ff - 1'b1);
      flags.table_ok   = valid_ff && (built_size_ff != '0);
   end

   always_comb begin
      priority if (cmd.capture || cmd.size_prep || cmd.sort_init || cmd.place_init)
         idx_in = '0;
      else if (cmd.kraft_init)
         idx_in = CNT_W'(1);
      else if (cmd.first_init)
         idx_in = CNT_W'(maxb);
      else if (cmd.first_step)
         idx_in = idx_ff - 1'b1;
      else if (cmd.cnt_inc || cmd.kraft_step || cmd.place_step || cmd.sort_step ||
               cmd.dec_step)
         idx_in = idx_ff + 1'b1;
      else
         idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;

      if (cmd.size_prep) begin
         for (int i = 0; i <= MAX_LEN; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (cmd.cnt_inc) begin
         counts_ff[LIDX_W'(len_rdata)] <= counts_ff[LIDX_W'(len_rdata)] + 1'b1;
      end

      if (cmd.kraft_init) begin
         avail_ff <= AV_W'(1);
      end else if (cmd.kraft_step) begin
         avail_ff <= avail_in;
      end

      // First codes are assigned from the longest length downward.
      if (cmd.first_init) begin
         sum_ff <= '0;
      end else if (cmd.first_step) begin
         first_ff[LIDX_W'(lidx - 1'b1)] <= sum_ff[MAX_LEN-1:0];
         sum_ff <= sum_add[SUM_W:1];
      end

      if (cmd.place_init) begin
         off_ff <= counts_ff[0];
      end else if (cmd.place_step) begin
         off_ff          <= off_in;
         base_ff[lidx]   <= cfg_size - off_in;
         cursor_ff[lidx] <= cfg_size - off_in;
      end else if (sort_we) begin
         cursor_ff[slot] <= cursor_ff[slot] + 1'b1;
      end

      if (cmd.commit) begin
         built_max_ff  <= maxb;
         built_size_ff <= cfg_size;
      end

      if (cmd.capture) begin
         v_ff    <= '0;
         win_ff  <= req_bit_window;
         fill_ff <= req_bits_available;
      end else if (cmd.dec_step) begin
         v_ff   <= v_cur;
         win_ff <= win_ff >> 1;
      end

      if (cmd.capture) begin
         res_status_ff <= cmd.status;
         res_symbol_ff <= '0;
         res_used_ff   <= '0;
      end else begin
         if (cmd.set_status) res_status_ff <= cmd.status;
         if (cmd.dec_read)   res_used_ff   <= chtd_pkg::USED_W'(lidx + 1'b1);
         if (cmd.dec_data)   res_symbol_ff <= sym_rdata;
      end

      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_symbol_ff <= res_symbol_ff;
         out_used_ff   <= res_used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         valid_ff <= 1'b1;
      end else if (cmd.size_prep) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_status    = out_status_ff;
   assign rsp_symbol    = out_symbol_ff;
   assign rsp_bits_used = out_used_ff;

endmodule

// ===== hdl/chtd_checker.sv =====
// ----------------------------------------------------------------------------
// chtd_checker
// Port-level checks for the canonical Huffman table decoder.
// ----------------------------------------------------------------------------
module chtd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [chtd_pkg::ST_W-1:0]      rsp_status,
   input logic [chtd_pkg::SYM_W-1:0]     rsp_symbol,
   input logic [chtd_pkg::USED_W-1:0]    rsp_bits_used
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_symbol) && $stable(rsp_bits_used))
      else $error("result changed while stalled");

   // Commands are worked one at a time, so a transfer closes the input side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a command was in flight");

   // Only a successful decode reports a symbol or consumed bits.
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != chtd_pkg::ST_OK |-> rsp_symbol == '0 &&
      rsp_bits_used == '0)
      else $error("failed result carries a symbol");

   // Decoded codes are never longer than the longest supported length.
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_bits_used) <= chtd_pkg::MAX_LEN)
      else $error("bits used out of range");

endmodule

bind canonical_huffman_table_decoder_core chtd_checker u_chtd_checker (.*);
